@@ sv/sqvm_pkg.sv @@
`timescale 1ns / 1ps

package sqvm_pkg;

   localparam int VOICES_DEF     = 8;
   localparam int OVERSAMPLE_DEF = 8;
   localparam int PHASE_BITS_DEF = 24;

   localparam int CMD_W    = 3;
   localparam int VOICE_W  = 3;
   localparam int INC_W    = 24;
   localparam int VOL_W    = 16;
   localparam int DUR_W    = 24;
   localparam int LEVEL_W  = 24;
   localparam int MASK_W   = 8;
   localparam int PRESET_W = 16;
   localparam int GAIN_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // one voice-substep contributes at most 12 quarters of its volume
   localparam int WEIGHT_W = 4;
   localparam int QUART_W  = VOL_W + WEIGHT_W;
   localparam int GAIN_SHIFT = 17;

   localparam logic [GAIN_W-1:0]  GAIN_UNITY = 16'd32768;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 24'hFFFFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 3'd0,
      CMD_START    = 3'd1,
      CMD_RETUNE   = 3'd2,
      CMD_STOP     = 3'd3,
      CMD_STOP_ALL = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      MIX_ADD      = 3'd0,
      MIX_WEIGHTED = 3'd1,
      MIX_AND      = 3'd2,
      MIX_OR       = 3'd3,
      MIX_XOR      = 3'd4
   } mix_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GATE_SOURCES  = 3'd0,
      CSR_OUTPUT_EN     = 3'd1,
      CSR_MIX_MODE      = 3'd2,
      CSR_NOTE_CUT_EN   = 3'd3,
      CSR_PHASE_RST_EN  = 3'd4,
      CSR_PHASE_PRESETS = 3'd5,
      CSR_OUTPUT_GAIN   = 3'd6
   } csr_index_type;

   localparam logic [1:0] GATE_FIRST  = 2'd1;
   localparam logic [1:0] GATE_SECOND = 2'd2;

endpackage

@@ sv/sqvm_if.sv @@
`timescale 1ns / 1ps

interface sqvm_req_if
   import sqvm_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [VOICE_W-1:0] voice;
   logic [INC_W-1:0]   increment_one;
   logic [INC_W-1:0]   increment_two;
   logic [INC_W-1:0]   increment_three;
   logic [VOL_W-1:0]   volume;
   logic [DUR_W-1:0]   duration;

   modport source (output valid, cmd, voice, increment_one, increment_two,
                   increment_three, volume, duration, input ready);
   modport sink   (input valid, cmd, voice, increment_one, increment_two,
                   increment_three, volume, duration, output ready);
endinterface

interface sqvm_rsp_if
   import sqvm_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;
   logic [MASK_W-1:0]  active_voices;

   modport source (output valid, level, active_voices, input ready);
   modport sink   (input valid, level, active_voices, output ready);
endinterface

interface sqvm_csr_if
   import sqvm_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/one_bit_square_voice_mixer.sv @@
`timescale 1ns / 1ps
// channel   dir  payload                                             beat
// req_bus   in   cmd, voice, increment_one/two/three, volume, duration  valid & ready
// rsp_bus   out  level, active_voices (one beat per tick command)      valid & ready
// csr_bus   in   index, data (register write)                          valid & ready
//
// Non-tick commands are taken while idle and the block stays ready. A tick's result
// passes through the shared voice update unit, one voice-substep per cycle, then a drain
// state for the mix stage, a gain multiply state and the output register load. req_bus.ready
// is high only while idle; a tick waits in its last state while the previous result has
// not been taken. Synchronous reset clears the voice on flags, gate bits, countdowns and
// phase accumulators, but not the phase steps or volumes.
module one_bit_square_voice_mixer
   import sqvm_pkg::*;
#(
   parameter int VOICES     = VOICES_DEF,
   parameter int OVERSAMPLE = OVERSAMPLE_DEF,
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sqvm_req_if.sink   req_bus,
   sqvm_rsp_if.source rsp_bus,
   sqvm_csr_if.sink   csr_bus
);

   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int SUB_W  = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
   localparam int SUM_W  = QUART_W + $clog2(VOICES * OVERSAMPLE);
   localparam int PROD_W = SUM_W + GAIN_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RUN   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_MULT  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [VIDX_W-1:0] vcnt_ff, vcnt_in;
   logic [SUB_W-1:0]  sub_ff, sub_in;

   logic [5:0]            gate_src_ff, gate_src_in;
   logic [2:0]            out_en_ff, out_en_in;
   logic [2:0]            mix_mode_ff, mix_mode_in;
   logic                  cut_en_ff, cut_en_in;
   logic [2:0]            prst_en_ff, prst_en_in;
   logic [3*PRESET_W-1:0] presets_ff, presets_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;

   logic [PHASE_BITS-1:0] acc_ff [VOICES][3];
   logic [PHASE_BITS-1:0] acc_in [VOICES][3];
   logic [PHASE_BITS-1:0] step_ff [VOICES][3];
   logic [PHASE_BITS-1:0] step_in [VOICES][3];
   logic [2:0]            bits_ff [VOICES];
   logic [2:0]            bits_in [VOICES];
   logic [DUR_W-1:0]      cd_ff [VOICES];
   logic [DUR_W-1:0]      cd_in [VOICES];
   logic [VOL_W-1:0]      amp_ff [VOICES];
   logic [VOL_W-1:0]      amp_in [VOICES];
   logic [VOICES-1:0]     on_ff, on_in;

   logic             mix_vld_ff, mix_vld_in;
   logic [2:0]       mix_bits_ff, mix_bits_in;
   logic [VOL_W-1:0] mix_vol_ff, mix_vol_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   logic               rsp_vld_ff, rsp_vld_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;

   logic                  req_fire;
   logic                  voice_ok;
   logic [VIDX_W-1:0]     req_v;
   logic [PHASE_BITS-1:0] req_step [3];
   logic [PHASE_BITS-1:0] req_preset [3];

   logic [DUR_W-1:0]      cd_dec;
   logic                  cut_run;
   logic                  cut_stop;
   logic [2:0]            gate;
   logic [PHASE_BITS-1:0] nacc [3];
   logic [2:0]            nbit;

   logic [2:0]          en_bits;
   logic [WEIGHT_W-1:0] weight;
   logic [QUART_W-1:0]  quarters;
   logic [GAIN_W-1:0]   gain_sat;
   logic [PROD_W-1:0]   shifted;
   logic [MASK_W-1:0]   mask_w;

   function automatic logic gate_pick(input logic [1:0] code, input logic first,
                                      input logic second);
      logic g;
      if (code == GATE_FIRST) begin
         g = first;
      end else if (code == GATE_SECOND) begin
         g = second;
      end else begin
         g = 1'b1;
      end
      return g;
   endfunction

   function automatic logic [PHASE_BITS-1:0] scale_step(input logic [INC_W-1:0] inc);
      logic [PHASE_BITS+INC_W-1:0] wide;
      wide = {inc, PHASE_BITS'(0)};
      return wide[PHASE_BITS+INC_W-1 -: PHASE_BITS];
   endfunction

   function automatic logic [PHASE_BITS-1:0] preset_phase(input logic [PRESET_W-1:0] p);
      logic [PHASE_BITS+PRESET_W-1:0] wide;
      wide = {p, PHASE_BITS'(0)};
      return wide[PHASE_BITS+PRESET_W-1 -: PHASE_BITS];
   endfunction

   assign req_fire = req_bus.valid && req_bus.ready;
   assign req_v    = VIDX_W'(req_bus.voice);
   assign voice_ok = 32'(req_bus.voice) < VOICES;

   assign req_step[0] = scale_step(req_bus.increment_one);
   assign req_step[1] = scale_step(req_bus.increment_two);
   assign req_step[2] = scale_step(req_bus.increment_three);

   genvar gk;
   generate
      for (gk = 0; gk < 3; gk++) begin : g_preset
         assign req_preset[gk] = preset_phase(presets_ff[gk*PRESET_W +: PRESET_W]);
      end
   endgenerate

   // voice update unit, one voice-substep per cycle
   always_comb begin
      cd_dec   = cd_ff[vcnt_ff] - 1'b1;
      cut_run  = cut_en_ff && (cd_ff[vcnt_ff] != '0);
      cut_stop = cut_run && (cd_dec == '0);
      gate[0] = gate_pick(gate_src_ff[1:0], bits_ff[vcnt_ff][1], bits_ff[vcnt_ff][2]);
      gate[1] = gate_pick(gate_src_ff[3:2], bits_ff[vcnt_ff][0], bits_ff[vcnt_ff][2]);
      gate[2] = gate_pick(gate_src_ff[5:4], bits_ff[vcnt_ff][0], bits_ff[vcnt_ff][1]);
      for (int k = 0; k < 3; k++) begin
         if (gate[k]) begin
            nacc[k] = acc_ff[vcnt_ff][k] + step_ff[vcnt_ff][k];
            nbit[k] = nacc[k][PHASE_BITS-1];
         end else begin
            nacc[k] = acc_ff[vcnt_ff][k];
            nbit[k] = bits_ff[vcnt_ff][k];
         end
      end
   end

   // mix stage: weight in quarters of a volume unit
   always_comb begin
      en_bits = out_en_ff & mix_bits_ff;
      unique case (mix_mode_ff)
         MIX_ADD: begin
            weight = {2'(en_bits[0]) + 2'(en_bits[1]) + 2'(en_bits[2]), 2'b00};
         end
         MIX_WEIGHTED: begin
            weight = {1'b0, en_bits};
         end
         MIX_AND: begin
            weight = (&(mix_bits_ff | ~out_en_ff)) ? 4'd4 : 4'd0;
         end
         MIX_OR: begin
            weight = (|en_bits) ? 4'd4 : 4'd0;
         end
         MIX_XOR: begin
            weight = (^en_bits) ? 4'd4 : 4'd0;
         end
         default: begin
            weight = '0;
         end
      endcase
      quarters = QUART_W'(mix_vol_ff) * QUART_W'(weight);
   end

   assign gain_sat = (gain_ff > GAIN_UNITY) ? GAIN_UNITY : gain_ff;
   assign shifted  = prod_ff >> GAIN_SHIFT;

   genvar gv;
   generate
      for (gv = 0; gv < MASK_W; gv++) begin : g_mask
         if (gv < VOICES) begin : g_on
            assign mask_w[gv] = on_ff[gv];
         end else begin : g_off
            assign mask_w[gv] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      state_in    = state_ff;
      vcnt_in     = vcnt_ff;
      sub_in      = sub_ff;
      gate_src_in = gate_src_ff;
      out_en_in   = out_en_ff;
      mix_mode_in = mix_mode_ff;
      cut_en_in   = cut_en_ff;
      prst_en_in  = prst_en_ff;
      presets_in  = presets_ff;
      gain_in     = gain_ff;
      acc_in      = acc_ff;
      step_in     = step_ff;
      bits_in     = bits_ff;
      cd_in       = cd_ff;
      amp_in      = amp_ff;
      on_in       = on_ff;
      mix_vld_in  = 1'b0;
      mix_bits_in = mix_bits_ff;
      mix_vol_in  = mix_vol_ff;
      sum_in      = sum_ff;
      prod_in     = prod_ff;
      rsp_vld_in  = rsp_vld_ff;
      level_in    = level_ff;
      mask_in     = mask_ff;

      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_GATE_SOURCES:  gate_src_in = csr_bus.data[5:0];
            CSR_OUTPUT_EN:     out_en_in   = csr_bus.data[2:0];
            CSR_MIX_MODE:      mix_mode_in = csr_bus.data[2:0];
            CSR_NOTE_CUT_EN:   cut_en_in   = csr_bus.data[0];
            CSR_PHASE_RST_EN:  prst_en_in  = csr_bus.data[2:0];
            CSR_PHASE_PRESETS: presets_in  = csr_bus.data[3*PRESET_W-1:0];
            CSR_OUTPUT_GAIN:   gain_in     = csr_bus.data[GAIN_W-1:0];
            default: ;
         endcase
      end

      if (rsp_vld_ff && rsp_bus.ready) begin
         rsp_vld_in = 1'b0;
      end

      if (mix_vld_ff) begin
         sum_in = sum_ff + SUM_W'(quarters);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_bus.cmd)
                  CMD_TICK: begin
                     state_in = ST_RUN;
                     vcnt_in  = '0;
                     sub_in   = '0;
                     sum_in   = '0;
                  end
                  CMD_START: begin
                     if (voice_ok) begin
                        for (int k = 0; k < 3; k++) begin
                           step_in[req_v][k] = req_step[k];
                           if (prst_en_ff[k]) begin
                              acc_in[req_v][k] = req_preset[k];
                           end
                        end
                        amp_in[req_v] = req_bus.volume;
                        cd_in[req_v]  = req_bus.duration;
                        on_in[req_v]  = 1'b1;
                     end
                  end
                  CMD_RETUNE: begin
                     if (voice_ok) begin
                        for (int k = 0; k < 3; k++) begin
                           step_in[req_v][k] = req_step[k];
                        end
                     end
                  end
                  CMD_STOP: begin
                     if (voice_ok) begin
                        on_in[req_v] = 1'b0;
                     end
                  end
                  CMD_STOP_ALL: begin
                     on_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            if (on_ff[vcnt_ff]) begin
               if (cut_run) begin
                  cd_in[vcnt_ff] = cd_dec;
               end
               if (cut_stop) begin
                  on_in[vcnt_ff] = 1'b0;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     acc_in[vcnt_ff][k] = nacc[k];
                  end
                  bits_in[vcnt_ff] = nbit;
                  mix_vld_in       = 1'b1;
                  mix_bits_in      = nbit;
                  mix_vol_in       = amp_ff[vcnt_ff];
               end
            end
            if (vcnt_ff == VIDX_W'(VOICES - 1)) begin
               vcnt_in = '0;
               if (sub_ff == SUB_W'(OVERSAMPLE - 1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  sub_in = sub_ff + 1'b1;
               end
            end else begin
               vcnt_in = vcnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            prod_in  = PROD_W'(sum_ff) * PROD_W'(gain_sat);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_bus.ready) begin
               level_in   = (shifted > PROD_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                           : shifted[LEVEL_W-1:0];
               mask_in    = mask_w;
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         vcnt_ff     <= '0;
         sub_ff      <= '0;
         gate_src_ff <= '0;
         out_en_ff   <= 3'd7;
         mix_mode_ff <= MIX_ADD;
         cut_en_ff   <= 1'b0;
         prst_en_ff  <= '0;
         presets_ff  <= '0;
         gain_ff     <= GAIN_UNITY;
         on_ff       <= '0;
         mix_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         for (int v = 0; v < VOICES; v++) begin
            bits_ff[v] <= '0;
            cd_ff[v]   <= '0;
            for (int k = 0; k < 3; k++) begin
               acc_ff[v][k] <= '0;
            end
         end
      end else begin
         state_ff    <= state_in;
         vcnt_ff     <= vcnt_in;
         sub_ff      <= sub_in;
         gate_src_ff <= gate_src_in;
         out_en_ff   <= out_en_in;
         mix_mode_ff <= mix_mode_in;
         cut_en_ff   <= cut_en_in;
         prst_en_ff  <= prst_en_in;
         presets_ff  <= presets_in;
         gain_ff     <= gain_in;
         on_ff       <= on_in;
         mix_vld_ff  <= mix_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         bits_ff     <= bits_in;
         cd_ff       <= cd_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      amp_ff      <= amp_in;
      mix_bits_ff <= mix_bits_in;
      mix_vol_ff  <= mix_vol_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      level_ff    <= level_in;
      mask_ff     <= mask_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_vld_ff;
   assign rsp_bus.level         = level_ff;
   assign rsp_bus.active_voices = mask_ff;

   a_idle_no_mix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mix_vld_ff)
      else $error("mix stage busy while idle");

   a_mix_window: assert property (@(posedge clock) disable iff (reset)
      mix_vld_ff |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("mix beat outside tick");

   a_cut_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && on_ff[vcnt_ff] && cut_stop) |=> !mix_vld_ff)
      else $error("cut voice reached the mix");

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (32'(sub_ff) < OVERSAMPLE && 32'(vcnt_ff) < VOICES))
      else $error("sequencer counter out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_OUT))
      else $error("result beat without finished tick");

endmodule
